// ===== hdl/smh_pkg.sv =====
// Shared types, constants and a helper function for the stepper move and homing block.
`timescale 1ns / 1ps
`default_nettype none

package smh_pkg;

  localparam int POS_W      = 32;
  localparam int HALF_W     = 16;
  localparam int ESC_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  // Wide enough for a position plus or minus the full soft-limit span.
  localparam int TGT_W      = POS_W + 3;

  localparam logic signed [POS_W-1:0] MIN_POS_RESET  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] MAX_POS_RESET  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [HALF_W-1:0]       HOME_HP_RESET  = HALF_W'(1000);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_HOME = 2'd2,
    CMD_STOP = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STAGE_NONE   = 2'd0,
    STAGE_FIND   = 2'd1,
    STAGE_ESCAPE = 2'd2,
    STAGE_HOMED  = 2'd3
  } home_stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_POSITION     = 3'd0,
    REG_MAX_POSITION     = 3'd1,
    REG_HOME_DIRECTION   = 3'd2,
    REG_HOME_HALF_PERIOD = 3'd3,
    REG_ESCAPE_STEPS     = 3'd4,
    REG_FWD_PRESENT      = 3'd5,
    REG_BWD_PRESENT      = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic                    forward;
    logic                    running;
    logic [HALF_W-1:0]       half;
  } move_t;

  // Clamp a wide target to the soft limits, work out direction and run state, and force a nonzero half period.
  function automatic move_t start_move(input logic signed [TGT_W-1:0] tgt,
                                       input logic [HALF_W-1:0]       hp,
                                       input logic signed [POS_W-1:0] cur,
                                       input logic                    fwd,
                                       input logic signed [POS_W-1:0] min_pos,
                                       input logic signed [POS_W-1:0] max_pos);
    logic signed [TGT_W-1:0] t;
    move_t                   m;
    t = tgt;
    if (t < TGT_W'(min_pos)) t = TGT_W'(min_pos);
    if (t > TGT_W'(max_pos)) t = TGT_W'(max_pos);
    m.target  = t[POS_W-1:0];
    m.half    = (hp == '0) ? HALF_W'(1) : hp;
    if (m.target > cur)      m.forward = 1'b1;
    else if (m.target < cur) m.forward = 1'b0;
    else                     m.forward = fwd;
    m.running = (m.target != cur);
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smh_channels.sv =====
// Valid/ready channel interfaces for commands, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface smh_cmd_if import smh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic signed [POS_W-1:0] move_amount;
  logic                    absolute_move;
  logic                    move_direction;
  logic [HALF_W-1:0]       half_period;
  logic                    forward_limit;
  logic                    backward_limit;

  modport source (output valid, command, move_amount, absolute_move, move_direction,
                  half_period, forward_limit, backward_limit, input ready);
  modport sink (input valid, command, move_amount, absolute_move, move_direction,
                half_period, forward_limit, backward_limit, output ready);
endinterface

interface smh_res_if import smh_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    step_out;
  logic                    dir_out;
  logic signed [POS_W-1:0] position;
  logic                    running;
  logic [1:0]              home_stage;

  modport source (output valid, step_out, dir_out, position, running, home_stage,
                  input ready);
  modport sink (input valid, step_out, dir_out, position, running, home_stage,
                output ready);
endinterface

interface smh_cfg_if import smh_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/stepper_move_and_homing.sv =====
// Top level of the step/direction generator with soft limits and two-stage homing.
//
//  port  | role   | beat carries
//  ------+--------+-------------------------------------------------------------
//  cmd   | sink   | command, move_amount, absolute_move, move_direction,
//        |        | half_period, forward_limit, backward_limit
//  res   | source | step_out, dir_out, position, running, home_stage
//  cfg   | sink   | index, data (register write, always ready)
//
// Every command beat, tick or otherwise, is handled at once: the next state is formed
// in a single pass of logic and lands in the state and result registers together.
// One result beat comes out per command beat, in the cycle after it is accepted.
// cmd.ready is high whenever the result register is empty or being drained, so a
// stalled result holds its beat and blocks only the following command.
// Reset (rst, synchronous) clears the motion state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module stepper_move_and_homing import smh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  smh_cmd_if.sink   cmd,
  smh_res_if.source res,
  smh_cfg_if.sink   cfg
);

  // Configuration registers.
  logic signed [POS_W-1:0] min_position;
  logic signed [POS_W-1:0] max_position;
  logic                    home_direction;
  logic [HALF_W-1:0]       home_half_period;
  logic [ESC_W-1:0]        escape_steps;
  logic                    forward_limit_present;
  logic                    backward_limit_present;

  // Motion state.
  logic signed [POS_W-1:0] current_position, current_position_next;
  logic signed [POS_W-1:0] target_position, target_position_next;
  logic                    is_running, is_running_next;
  logic                    step_level, step_level_next;
  logic                    travel_forward, travel_forward_next;
  logic [HALF_W-1:0]       period_counter, period_counter_next;
  logic [HALF_W-1:0]       active_half_period, active_half_period_next;
  home_stage_t             homing_stage, homing_stage_next;

  // Result register.
  logic                    res_valid;
  logic                    res_step;
  logic                    res_dir;
  logic signed [POS_W-1:0] res_position;
  logic                    res_running;
  home_stage_t             res_stage;

  logic                    take;
  command_t                command;
  logic                    fwd_lim;
  logic                    bwd_lim;
  logic                    home_sw;
  logic                    travel_sw;
  logic                    home_ok;
  logic                    check;
  logic signed [TGT_W-1:0] cur_wide;
  logic signed [TGT_W-1:0] amount_wide;
  logic signed [TGT_W-1:0] span;
  logic signed [TGT_W-1:0] move_tgt;
  logic signed [TGT_W-1:0] home_tgt;
  logic signed [TGT_W-1:0] esc_tgt;
  move_t                   mv;

  assign cmd.ready = !res_valid || res.ready;
  assign cfg.ready = 1'b1;
  assign take      = cmd.valid && cmd.ready;
  assign command   = command_t'(cmd.command);

  assign fwd_lim   = cmd.forward_limit && forward_limit_present;
  assign bwd_lim   = cmd.backward_limit && backward_limit_present;
  assign home_sw   = home_direction ? fwd_lim : bwd_lim;
  assign travel_sw = travel_forward ? fwd_lim : bwd_lim;
  assign home_ok   = home_direction ? forward_limit_present : backward_limit_present;

  assign cur_wide    = TGT_W'(current_position);
  assign amount_wide = TGT_W'(cmd.move_amount);
  assign span        = TGT_W'(max_position) - TGT_W'(min_position);
  assign move_tgt    = cmd.absolute_move  ? amount_wide :
                       cmd.move_direction ? cur_wide + amount_wide : cur_wide - amount_wide;
  assign home_tgt    = home_direction ? cur_wide + span : cur_wide - span;

  always_comb begin
    current_position_next   = current_position;
    target_position_next    = target_position;
    is_running_next         = is_running;
    step_level_next         = step_level;
    travel_forward_next     = travel_forward;
    period_counter_next     = period_counter;
    active_half_period_next = active_half_period;
    homing_stage_next       = homing_stage;
    check                   = 1'b0;
    mv                      = '0;
    esc_tgt                 = '0;

    if (take) begin
      case (command)
        CMD_TICK: begin
          if (is_running) begin
            if (step_level) begin
              if (period_counter >= active_half_period) begin
                step_level_next     = 1'b0;
                period_counter_next = HALF_W'(1);
              end else begin
                period_counter_next = period_counter + HALF_W'(1);
              end
            end else if (period_counter == '0) begin
              check = 1'b1;
            end else if (period_counter >= active_half_period) begin
              // End of the low phase: count the pulse, then check again at once.
              current_position_next = travel_forward ? current_position + POS_W'(1)
                                                     : current_position - POS_W'(1);
              period_counter_next   = '0;
              check                 = 1'b1;
            end else begin
              period_counter_next = period_counter + HALF_W'(1);
            end
          end
        end
        CMD_MOVE: begin
          mv                      = start_move(move_tgt, cmd.half_period, current_position,
                                               travel_forward, min_position, max_position);
          homing_stage_next       = STAGE_NONE;
          step_level_next         = 1'b0;
          period_counter_next     = '0;
          target_position_next    = mv.target;
          travel_forward_next     = mv.forward;
          is_running_next         = mv.running;
          active_half_period_next = mv.half;
        end
        CMD_HOME: begin
          if (home_ok) begin
            mv                      = start_move(home_tgt, home_half_period, current_position,
                                                 travel_forward, min_position, max_position);
            homing_stage_next       = STAGE_FIND;
            step_level_next         = 1'b0;
            period_counter_next     = '0;
            target_position_next    = mv.target;
            travel_forward_next     = mv.forward;
            is_running_next         = mv.running;
            active_half_period_next = mv.half;
          end
        end
        CMD_STOP: begin
          if (is_running) begin
            is_running_next     = 1'b0;
            step_level_next     = 1'b0;
            period_counter_next = '0;
            if (homing_stage == STAGE_FIND || homing_stage == STAGE_ESCAPE) begin
              homing_stage_next = STAGE_NONE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (check) begin
      if (current_position_next == target_position) begin
        is_running_next     = 1'b0;
        step_level_next     = 1'b0;
        period_counter_next = '0;
        if (homing_stage == STAGE_ESCAPE) begin
          homing_stage_next     = STAGE_HOMED;
          current_position_next = '0;
        end
      end else if (homing_stage == STAGE_FIND && home_sw) begin
        // Home switch found: back off the other way at the homing rate.
        esc_tgt = home_direction ? TGT_W'(current_position_next) - TGT_W'(escape_steps)
                                 : TGT_W'(current_position_next) + TGT_W'(escape_steps);
        mv      = start_move(esc_tgt, home_half_period, current_position_next,
                             travel_forward, min_position, max_position);
        homing_stage_next       = STAGE_ESCAPE;
        step_level_next         = 1'b0;
        period_counter_next     = '0;
        target_position_next    = mv.target;
        travel_forward_next     = mv.forward;
        is_running_next         = mv.running;
        active_half_period_next = mv.half;
        if (!mv.running) begin
          homing_stage_next     = STAGE_HOMED;
          current_position_next = '0;
        end
      end else if ((homing_stage == STAGE_NONE || homing_stage == STAGE_HOMED) && travel_sw) begin
        is_running_next     = 1'b0;
        step_level_next     = 1'b0;
        period_counter_next = '0;
      end else begin
        step_level_next     = 1'b1;
        period_counter_next = HALF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_position           <= MIN_POS_RESET;
      max_position           <= MAX_POS_RESET;
      home_direction         <= 1'b0;
      home_half_period       <= HOME_HP_RESET;
      escape_steps           <= '0;
      forward_limit_present  <= 1'b0;
      backward_limit_present <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MIN_POSITION:     min_position           <= cfg.data[POS_W-1:0];
        REG_MAX_POSITION:     max_position           <= cfg.data[POS_W-1:0];
        REG_HOME_DIRECTION:   home_direction         <= cfg.data[0];
        REG_HOME_HALF_PERIOD: home_half_period       <= cfg.data[HALF_W-1:0];
        REG_ESCAPE_STEPS:     escape_steps           <= cfg.data[ESC_W-1:0];
        REG_FWD_PRESENT:      forward_limit_present  <= cfg.data[0];
        REG_BWD_PRESENT:      backward_limit_present <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position   <= '0;
      target_position    <= '0;
      is_running         <= 1'b0;
      step_level         <= 1'b0;
      travel_forward     <= 1'b0;
      period_counter     <= '0;
      active_half_period <= HALF_W'(1);
      homing_stage       <= STAGE_NONE;
    end else begin
      current_position   <= current_position_next;
      target_position    <= target_position_next;
      is_running         <= is_running_next;
      step_level         <= step_level_next;
      travel_forward     <= travel_forward_next;
      period_counter     <= period_counter_next;
      active_half_period <= active_half_period_next;
      homing_stage       <= homing_stage_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_step     <= step_level_next;
      res_dir      <= travel_forward_next;
      res_position <= current_position_next;
      res_running  <= is_running_next;
      res_stage    <= homing_stage_next;
    end
  end

  assign res.valid      = res_valid;
  assign res.step_out   = res_step;
  assign res.dir_out    = res_dir;
  assign res.position   = res_position;
  assign res.running    = res_running;
  assign res.home_stage = res_stage;

endmodule

`default_nettype wire

// ===== hdl/smh_checker.sv =====
// Port-level checks for the stepper block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module smh_checker import smh_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    cmd_ready,
  input wire logic                    res_valid,
  input wire logic                    res_ready,
  input wire logic                    step_out,
  input wire logic signed [POS_W-1:0] position,
  input wire logic                    running,
  input wire logic [1:0]              home_stage
);

  // The step line is only ever high while a move runs.
  a_step_needs_run: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (running || !step_out))
    else $error("step_out high while not running");

  // An escape that is not running has already turned into homed or been cancelled.
  a_escape_runs: assert property (@(posedge clk) disable iff (rst)
    (res_valid && home_stage == STAGE_ESCAPE) |-> running)
    else $error("escape stage shown while idle");

  // The result register empties on reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // An empty result register never holds off commands.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("command not ready with empty result register");

  // A stalled result beat holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(position) && $stable(home_stage)))
    else $error("stalled result changed");

endmodule

bind stepper_move_and_homing smh_checker u_smh_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .step_out   (res.step_out),
  .position   (res.position),
  .running    (res.running),
  .home_stage (res.home_stage)
);

`default_nettype wire
